FILE: rtl/core/mfpr_pkg.sv
// ----------------------------------------------------------------------------
// mfpr_pkg
// Shared types and constants of the push-relabel max flow core.
// ----------------------------------------------------------------------------
`default_nettype none

package mfpr_pkg;

	localparam int MAX_VERTICES_DEF = 64;
	localparam int CAP_W            = 32;
	localparam int VTX_W            = 6;
	localparam int CNT_W            = 7;
	localparam int OUT_W            = 38;
	localparam int CFG_IDX_W        = 2;
	localparam int CFG_DATA_W       = 7;

	typedef enum logic [1:0] {
		CMD_ADD     = 2'd0,
		CMD_COMPUTE = 2'd1,
		CMD_CLEAR   = 2'd2,
		CMD_RSVD    = 2'd3
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SOURCE = 2'd0,
		CFG_SINK   = 2'd1,
		CFG_COUNT  = 2'd2,
		CFG_NONE   = 2'd3
	} cfg_idx_t;

	// One matrix cell: edge marker, capacity and current flow.
	typedef struct packed {
		logic             present;
		logic [CAP_W-1:0] cap;
		logic [CAP_W-1:0] flow;
	} edge_t;

	localparam int EDGE_W = $bits(edge_t);

endpackage

`default_nettype wire

FILE: rtl/core/mfpr_ram.sv
// ----------------------------------------------------------------------------
// mfpr_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mfpr_ram #(
	parameter int WIDTH = mfpr_pkg::EDGE_W,
	parameter int DEPTH = mfpr_pkg::MAX_VERTICES_DEF * mfpr_pkg::MAX_VERTICES_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

FILE: rtl/core/max_flow_push_relabel_core.sv
// ----------------------------------------------------------------------------
// max_flow_push_relabel_core
// Push-relabel maximum flow on a dense adjacency-matrix graph.
// ----------------------------------------------------------------------------
// The graph lives in one edge RAM of MAX_VERTICES^2 words (capacity, flow,
// edge marker) and the heights and excess in a small vertex RAM; both are
// single-read-port with a registered read. After reset, and for each clear
// word, the edge RAM is swept to zero with in_ready low. A compute word first
// clears the flow, then saturates the source edges, then repeats push or
// relabel steps, each finding the lowest overflowing vertex, scanning its
// neighbors and writing back, and finally sums the source flow. One word is
// worked on at a time; a finished result waits in the output register while
// the next word is taken.
`default_nettype none

module max_flow_push_relabel_core #(
	parameter int MAX_VERTICES = mfpr_pkg::MAX_VERTICES_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [1:0]                      cmd,
	input  wire logic [mfpr_pkg::VTX_W-1:0]      from_vertex,
	input  wire logic [mfpr_pkg::VTX_W-1:0]      to_vertex,
	input  wire logic [mfpr_pkg::CAP_W-1:0]      capacity,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [mfpr_pkg::OUT_W-1:0]           max_flow,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [mfpr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [mfpr_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int CELLS = MAX_VERTICES * MAX_VERTICES;
	localparam int AW    = $clog2(CELLS);
	localparam int VW    = $clog2(MAX_VERTICES);
	localparam int VCW   = $clog2(MAX_VERTICES + 1);
	localparam int HW    = $clog2(2 * MAX_VERTICES) + 1;
	localparam int EW    = mfpr_pkg::CAP_W + VW + 1;
	localparam int NW    = mfpr_pkg::CAP_W + VW + 2;
	localparam int VEW   = HW + EW;
	localparam int CW    = mfpr_pkg::CAP_W;
	localparam int MAX_VERTICES_CLAMP = 64;

	typedef enum logic [16:0] {
		ST_CLR   = 17'h00001,
		ST_IDLE  = 17'h00002,
		ST_ADD   = 17'h00004,
		ST_ZERO  = 17'h00008,
		ST_SAT   = 17'h00010,
		ST_SATF  = 17'h00020,
		ST_FIND  = 17'h00040,
		ST_P0    = 17'h00080,
		ST_P1    = 17'h00100,
		ST_P2    = 17'h00200,
		ST_PW1   = 17'h00400,
		ST_PW2   = 17'h00800,
		ST_RELAB = 17'h01000,
		ST_SUM0  = 17'h02000,
		ST_SUM1  = 17'h04000,
		ST_SUM2  = 17'h08000,
		ST_RES   = 17'h10000
	} state_t;

	function automatic logic [AW-1:0] cell_addr(input logic [VW-1:0] r, input logic [VW-1:0] c);
		cell_addr = AW'(32'(r) * 32'(MAX_VERTICES) + 32'(c));
	endfunction

	state_t state_q;
	logic [AW:0]     idx_q;
	logic [VCW-1:0]  vi_q;
	logic [VCW-1:0]  n_q;
	logic [mfpr_pkg::VTX_W-1:0] src_q, snk_q, s_q, t_q;
	logic [mfpr_pkg::CNT_W-1:0] cnt_q;
	logic [VW-1:0]   u_q;
	logic [HW-1:0]   hu_q, hv_q, min_q;
	logic signed [EW-1:0] exu_q, exv_q, src_ex_q;
	logic signed [NW-1:0] net_q;
	mfpr_pkg::edge_t auv_q, avu_q;
	logic [EW-1:0]   d_q;
	logic [CW-1:0]   back_q, fsv_q, add_cap_q;
	logic [AW-1:0]   add_addr_q;
	logic            found_q;
	logic            out_valid_q;
	logic [mfpr_pkg::OUT_W-1:0] max_flow_q;

	logic                 a_we, v_we;
	logic [AW-1:0]        a_waddr, a_raddr;
	logic [mfpr_pkg::EDGE_W-1:0] a_wdata, a_rdata;
	logic [VW-1:0]        v_waddr, v_raddr;
	logic [VEW-1:0]       v_wdata, v_rdata;

	mfpr_ram #(.WIDTH(mfpr_pkg::EDGE_W), .DEPTH(CELLS), .AW(AW)) u_edge_ram (
		.clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
		.raddr(a_raddr), .rdata(a_rdata)
	);

	mfpr_ram #(.WIDTH(VEW), .DEPTH(MAX_VERTICES), .AW(VW)) u_vtx_ram (
		.clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
		.raddr(v_raddr), .rdata(v_rdata)
	);

	mfpr_pkg::edge_t      a_e;
	logic [HW-1:0]        v_h;
	logic signed [EW-1:0] v_ex;
	logic [VCW-1:0]       pv;
	logic [VW-1:0]        vi_v, s_v;
	logic                 in_fire, add_ok, find_hit, sat_hit, admis, last_nb;
	logic [CW:0]          fwd, r_c, sum_c;
	logic [CW-1:0]        sat_c;
	logic [EW-1:0]        d_c;
	logic [CW-1:0]        back_c;
	logic [VCW-1:0]       n_eff;

	assign a_e  = mfpr_pkg::edge_t'(a_rdata);
	assign v_h  = v_rdata[VEW-1:EW];
	assign v_ex = signed'(v_rdata[EW-1:0]);
	assign pv   = vi_q - VCW'(1);
	assign vi_v = vi_q[VW-1:0];
	assign s_v  = VW'(s_q);

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign max_flow  = max_flow_q;

	assign add_ok = (32'(from_vertex) < 32'(MAX_VERTICES)) && (32'(to_vertex) < 32'(MAX_VERTICES));
	assign n_eff  = (32'(cnt_q) > 32'(MAX_VERTICES)) ? VCW'(MAX_VERTICES) : VCW'(cnt_q);

	// saturating capacity add
	assign sum_c = {1'b0, a_e.cap} + {1'b0, add_cap_q};
	assign sat_c = sum_c[CW] ? {CW{1'b1}} : sum_c[CW-1:0];

	assign sat_hit  = (vi_q != '0) && (32'(pv) != 32'(s_q)) && a_e.present;
	assign find_hit = (vi_q != '0) && (32'(pv) != 32'(s_q)) && (32'(pv) != 32'(t_q)) &&
		!v_ex[EW-1] && (v_ex != '0);

	// residual u->v, a_rdata holds cell (v,u) in ST_P2
	assign fwd    = auv_q.present ? ({1'b0, auv_q.cap} - {1'b0, auv_q.flow}) : '0;
	assign r_c    = (u_q == vi_v) ? '0 : fwd + {1'b0, a_e.flow};
	assign admis  = (r_c != '0) && ({1'b0, hu_q} == ({1'b0, hv_q} + (HW+1)'(1)));
	assign d_c    = (EW'(r_c) < unsigned'(exu_q)) ? EW'(r_c) : unsigned'(exu_q);
	assign back_c = (EW'(a_e.flow) < d_c) ? a_e.flow : d_c[CW-1:0];
	assign last_nb = (vi_q == n_q - VCW'(1));

	always_comb begin
		case (state_q)
			ST_IDLE: a_raddr = cell_addr(VW'(from_vertex), VW'(to_vertex));
			ST_ZERO: a_raddr = idx_q[AW-1:0];
			ST_SAT:  a_raddr = cell_addr(s_v, vi_v);
			ST_P0:   a_raddr = cell_addr(u_q, vi_v);
			ST_P1:   a_raddr = cell_addr(vi_v, u_q);
			ST_SUM0: a_raddr = cell_addr(s_v, vi_v);
			ST_SUM1: a_raddr = cell_addr(vi_v, s_v);
			default: a_raddr = '0;
		endcase
	end

	assign v_raddr = vi_v;

	always_comb begin
		a_we    = 1'b0;
		a_waddr = '0;
		a_wdata = '0;
		v_we    = 1'b0;
		v_waddr = '0;
		v_wdata = '0;
		case (state_q)
			ST_CLR: begin
				a_we    = 1'b1;
				a_waddr = idx_q[AW-1:0];
			end
			ST_ADD: begin
				a_we    = 1'b1;
				a_waddr = add_addr_q;
				a_wdata = {1'b1, sat_c, a_e.flow};
			end
			ST_ZERO: begin
				// write back the cell read in the previous cycle with its flow cleared
				a_we    = (idx_q != '0);
				a_waddr = AW'(idx_q - (AW+1)'(1));
				a_wdata = {a_e.present, a_e.cap, {CW{1'b0}}};
				v_we    = (32'(idx_q) < 32'(MAX_VERTICES));
				v_waddr = idx_q[VW-1:0];
			end
			ST_SAT: begin
				a_we    = sat_hit;
				a_waddr = cell_addr(s_v, pv[VW-1:0]);
				a_wdata = {a_e.present, a_e.cap, a_e.cap};
				v_we    = sat_hit;
				v_waddr = pv[VW-1:0];
				v_wdata = {{HW{1'b0}}, EW'(a_e.cap)};
			end
			ST_SATF: begin
				v_we    = 1'b1;
				v_waddr = s_v;
				v_wdata = {HW'(n_q), src_ex_q};
			end
			ST_PW1: begin
				a_we    = 1'b1;
				a_waddr = cell_addr(vi_v, u_q);
				a_wdata = {avu_q.present, avu_q.cap, avu_q.flow - back_q};
				v_we    = 1'b1;
				v_waddr = u_q;
				v_wdata = {hu_q, exu_q - signed'(d_q)};
			end
			ST_PW2: begin
				a_we    = 1'b1;
				a_waddr = cell_addr(u_q, vi_v);
				a_wdata = {auv_q.present, auv_q.cap, auv_q.flow + (d_q[CW-1:0] - back_q)};
				v_we    = 1'b1;
				v_waddr = vi_v;
				v_wdata = {hv_q, exv_q + signed'(d_q)};
			end
			ST_RELAB: begin
				v_we    = 1'b1;
				v_waddr = u_q;
				v_wdata = found_q ? {min_q + HW'(1), exu_q} : {hu_q, {EW{1'b0}}};
			end
			default: begin
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q <= '0;
			snk_q <= mfpr_pkg::VTX_W'(1);
			cnt_q <= mfpr_pkg::CNT_W'(MAX_VERTICES_CLAMP);
		end else if (cfg_valid && cfg_ready) begin
			case (mfpr_pkg::cfg_idx_t'(cfg_index))
				mfpr_pkg::CFG_SOURCE: src_q <= cfg_data[mfpr_pkg::VTX_W-1:0];
				mfpr_pkg::CFG_SINK:   snk_q <= cfg_data[mfpr_pkg::VTX_W-1:0];
				mfpr_pkg::CFG_COUNT:  cnt_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			idx_q       <= '0;
			vi_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && (state_q != ST_RES)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLR: begin
					idx_q <= idx_q + (AW+1)'(1);
					if (idx_q == (AW+1)'(CELLS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_fire) begin
						case (mfpr_pkg::cmd_t'(cmd))
							mfpr_pkg::CMD_ADD: begin
								if (add_ok) begin
									state_q <= ST_ADD;
								end
							end
							mfpr_pkg::CMD_COMPUTE: begin
								idx_q   <= '0;
								state_q <= ST_ZERO;
							end
							mfpr_pkg::CMD_CLEAR: begin
								idx_q   <= '0;
								state_q <= ST_CLR;
							end
							default: begin
							end
						endcase
					end
				end
				ST_ADD: state_q <= ST_IDLE;
				ST_ZERO: begin
					idx_q <= idx_q + (AW+1)'(1);
					vi_q  <= '0;
					if (idx_q == (AW+1)'(CELLS)) begin
						state_q <= (32'(s_q) >= 32'(n_q)) ? ST_RES : ST_SAT;
					end
				end
				ST_SAT: begin
					vi_q <= vi_q + VCW'(1);
					if (vi_q == n_q) begin
						state_q <= ST_SATF;
					end
				end
				ST_SATF: begin
					vi_q    <= '0;
					state_q <= ST_FIND;
				end
				ST_FIND: begin
					if (find_hit) begin
						vi_q    <= '0;
						state_q <= ST_P0;
					end else if (vi_q == n_q) begin
						vi_q    <= '0;
						state_q <= ST_SUM0;
					end else begin
						vi_q <= vi_q + VCW'(1);
					end
				end
				ST_P0: state_q <= ST_P1;
				ST_P1: state_q <= ST_P2;
				ST_P2: begin
					if (admis) begin
						state_q <= ST_PW1;
					end else if (last_nb) begin
						state_q <= ST_RELAB;
					end else begin
						vi_q    <= vi_q + VCW'(1);
						state_q <= ST_P0;
					end
				end
				ST_PW1: state_q <= ST_PW2;
				ST_PW2: begin
					vi_q    <= '0;
					state_q <= ST_FIND;
				end
				ST_RELAB: begin
					vi_q    <= '0;
					state_q <= ST_FIND;
				end
				ST_SUM0: state_q <= ST_SUM1;
				ST_SUM1: state_q <= ST_SUM2;
				ST_SUM2: begin
					if (last_nb) begin
						state_q <= ST_RES;
					end else begin
						vi_q    <= vi_q + VCW'(1);
						state_q <= ST_SUM0;
					end
				end
				ST_RES: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_CLR;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				add_addr_q <= cell_addr(VW'(from_vertex), VW'(to_vertex));
				add_cap_q  <= capacity;
				n_q        <= n_eff;
				s_q        <= src_q;
				t_q        <= snk_q;
				src_ex_q   <= '0;
				net_q      <= '0;
			end
			ST_SAT: begin
				if (sat_hit) begin
					src_ex_q <= src_ex_q - signed'(EW'(a_e.cap));
				end
			end
			ST_FIND: begin
				u_q     <= pv[VW-1:0];
				hu_q    <= v_h;
				exu_q   <= v_ex;
				found_q <= 1'b0;
				min_q   <= '0;
			end
			ST_P1: begin
				auv_q <= a_e;
				hv_q  <= v_h;
				exv_q <= v_ex;
			end
			ST_P2: begin
				avu_q  <= a_e;
				d_q    <= d_c;
				back_q <= back_c;
				if (!admis && (r_c != '0) && (!found_q || (hv_q < min_q))) begin
					min_q   <= hv_q;
					found_q <= 1'b1;
				end
			end
			ST_SUM1: fsv_q <= a_e.flow;
			ST_SUM2: begin
				if (32'(vi_q) != 32'(s_q)) begin
					net_q <= net_q + signed'(NW'(fsv_q)) - signed'(NW'(a_e.flow));
				end
			end
			ST_RES: begin
				if (!out_valid_q || out_ready) begin
					max_flow_q <= net_q[NW-1] ? '0 : mfpr_pkg::OUT_W'(unsigned'(net_q));
				end
			end
			default: begin
			end
		endcase
	end

	// a swept write never hits the cell being read in the same cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(a_we && (state_q == ST_ZERO || state_q == ST_SAT)) |-> (a_waddr != a_raddr))
		else $error("edge RAM sweep write collides with read");

	// a push always moves a nonzero amount
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PW1) |-> (d_q != '0))
		else $error("push of zero flow");

	// a compute word holds off the input until its result is posted
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && (cmd == mfpr_pkg::CMD_COMPUTE)) |=> !in_ready)
		else $error("input taken during compute");

	// a new result is only loaded from the result state
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_RES))
		else $error("result posted outside result state");

endmodule

`default_nettype wire

FILE: bench/tb_max_flow_push_relabel_core.sv
// ----------------------------------------------------------------------------
// tb_max_flow_push_relabel_core
// Checks the push-relabel max flow core against its own software solver:
// edge loads, clears and compute words are driven under several
// source, sink and vertex count settings. Both handshakes are idled and
// stalled at random. Every max_flow result is compared in order.
// ----------------------------------------------------------------------------
`default_nettype none

// Graph mirror and solver; holds the flow values still owed by the core.
class maxflow_tracker;
	bit [31:0]         cap_cell [4096];
	bit                has_edge [4096];
	bit [31:0]         flow_cell[4096];
	int unsigned       level    [64];
	longint            surplus  [64];
	bit [5:0]          src_v;
	bit [5:0]          snk_v;
	bit [6:0]          n_vtx;
	bit [37:0]         pending_flows[$];
	int                errors;
	int                checked;

	function new();
		foreach (cap_cell[i]) begin
			cap_cell[i] = 0;
			has_edge[i] = 0;
			flow_cell[i] = 0;
		end
		src_v = 0;
		snk_v = 1;
		n_vtx = 64;
		errors = 0;
		checked = 0;
	endfunction

	function void set_reg(mfpr_pkg::cfg_idx_t idx, bit [6:0] data);
		case (idx)
			mfpr_pkg::CFG_SOURCE: src_v = data[5:0];
			mfpr_pkg::CFG_SINK:   snk_v = data[5:0];
			mfpr_pkg::CFG_COUNT:  n_vtx = data;
			default: ;
		endcase
	endfunction

	function longint unsigned resid(int u, int v);
		longint unsigned r;
		r = 0;
		if (u == v)
			return 0;
		if (has_edge[u*64+v])
			r = longint'(cap_cell[u*64+v]) - longint'(flow_cell[u*64+v]);
		return r + flow_cell[v*64+u];
	endfunction

	function bit push_from(int u, int n);
		longint unsigned r, d, back;
		for (int v = 0; v < n; v++) begin
			r = resid(u, v);
			if (r > 0 && level[u] == level[v] + 1) begin
				d = surplus[u];
				if (r < d)
					d = r;
				back = flow_cell[v*64+u];
				if (back > d)
					back = d;
				flow_cell[v*64+u] -= 32'(back);
				flow_cell[u*64+v] += 32'(d - back);
				surplus[u] -= longint'(d);
				surplus[v] += longint'(d);
				return 1;
			end
		end
		return 0;
	endfunction

	function void lift(int u, int n);
		bit          found;
		int unsigned lowest;
		found = 0;
		lowest = 0;
		for (int v = 0; v < n; v++)
			if (resid(u, v) > 0 && (!found || level[v] < lowest)) begin
				lowest = level[v];
				found = 1;
			end
		if (found)
			level[u] = lowest + 1;
		else
			surplus[u] = 0;
	endfunction

	function int first_active(int n);
		for (int i = 0; i < n; i++)
			if (i != src_v && i != snk_v && surplus[i] > 0)
				return i;
		return -1;
	endfunction

	function bit [37:0] predict_max_flow();
		int     n, s, u;
		longint net;
		n = (n_vtx > 64) ? 64 : n_vtx;
		s = src_v;
		net = 0;
		foreach (flow_cell[i])
			flow_cell[i] = 0;
		foreach (level[i]) begin
			level[i] = 0;
			surplus[i] = 0;
		end
		if (s >= n)
			return 0;
		level[s] = n;
		for (int v = 0; v < n; v++)
			if (v != s && has_edge[s*64+v]) begin
				flow_cell[s*64+v] = cap_cell[s*64+v];
				surplus[v] += cap_cell[s*64+v];
				surplus[s] -= cap_cell[s*64+v];
			end
		u = first_active(n);
		while (u >= 0) begin
			if (!push_from(u, n))
				lift(u, n);
			u = first_active(n);
		end
		for (int v = 0; v < n; v++)
			if (v != s) begin
				net += flow_cell[s*64+v];
				net -= flow_cell[v*64+s];
			end
		if (net < 0)
			return 0;
		return net[37:0];
	endfunction

	function void note_word(mfpr_pkg::cmd_t c, bit [5:0] a, bit [5:0] b, bit [31:0] w);
		longint unsigned sum;
		case (c)
			mfpr_pkg::CMD_ADD: begin
				sum = longint'(cap_cell[a*64+b]) + w;
				cap_cell[a*64+b] = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
				has_edge[a*64+b] = 1;
			end
			mfpr_pkg::CMD_COMPUTE: pending_flows = {pending_flows, predict_max_flow()};
			mfpr_pkg::CMD_CLEAR: begin
				foreach (cap_cell[i]) begin
					cap_cell[i] = 0;
					has_edge[i] = 0;
					flow_cell[i] = 0;
				end
			end
			default: ;
		endcase
	endfunction

	function void check_result(bit [37:0] got);
		bit [37:0] want;
		if (pending_flows.size() == 0) begin
			$display("%0t: unexpected max_flow, expected none, actual %0d", $time, got);
			errors++;
			return;
		end
		want = pending_flows.pop_front();
		checked++;
		if (got !== want) begin
			$display("%0t: max_flow mismatch, expected %0d, actual %0d", $time, want, got);
			errors++;
		end
	endfunction
endclass

module tb_max_flow_push_relabel_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 10_000_000;
	localparam int SETTLE_CYCLES  = 4400;

	logic                            clk;
	logic                            arst_n;
	logic                            in_valid;
	logic                            in_ready;
	logic [1:0]                      cmd;
	logic [mfpr_pkg::VTX_W-1:0]      from_vertex;
	logic [mfpr_pkg::VTX_W-1:0]      to_vertex;
	logic [mfpr_pkg::CAP_W-1:0]      capacity;
	logic                            out_valid;
	logic                            out_ready;
	logic [mfpr_pkg::OUT_W-1:0]      max_flow;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [mfpr_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [mfpr_pkg::CFG_DATA_W-1:0] cfg_data;

	maxflow_tracker tracker;
	int             in_idle_pct;
	int             out_stall_pct;
	int             words_sent;
	int             settings_used;
	int             quiet_cycles;

	max_flow_push_relabel_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .cmd(cmd),
		.from_vertex(from_vertex), .to_vertex(to_vertex), .capacity(capacity),
		.out_valid(out_valid), .out_ready(out_ready), .max_flow(max_flow),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	always @(negedge clk)
		out_ready <= ($urandom_range(0, 99) >= out_stall_pct);

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			tracker.check_result(max_flow);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
			$display("FAIL");
			$finish;
		end
	end

	task automatic send_word(mfpr_pkg::cmd_t c, bit [5:0] a, bit [5:0] b, bit [31:0] w);
		@(negedge clk);
		while ($urandom_range(0, 99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		cmd         <= c;
		from_vertex <= a;
		to_vertex   <= b;
		capacity    <= w;
		do @(posedge clk); while (!in_ready);
		tracker.note_word(c, a, b, w);
		words_sent++;
	endtask

	task automatic go_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (tracker.pending_flows.size() != 0)
			@(posedge clk);
		// clear or edge words may still be running after the last result
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(mfpr_pkg::cfg_idx_t idx, bit [6:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		tracker.set_reg(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic bit [31:0] pick_capacity();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 40)
			return $urandom_range(0, 20);
		else if (sel < 60)
			return $urandom;
		else if (sel < 70)
			return 0;
		else if (sel < 80)
			return 32'hFFFF_FFFF;
		return $urandom_range(0, 1000);
	endfunction

	task automatic run_phase(bit [5:0] src, bit [5:0] snk, bit [6:0] n, int mode, int budget);
		int nv, k, start;
		bit [5:0] a, b;
		go_idle();
		write_reg(mfpr_pkg::CFG_SOURCE, {1'b0, src});
		write_reg(mfpr_pkg::CFG_SINK, {1'b0, snk});
		write_reg(mfpr_pkg::CFG_COUNT, n);
		settings_used++;
		case (mode)
			0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
			1: begin in_idle_pct = 85; out_stall_pct = 0;  end
			2: begin in_idle_pct = 0;  out_stall_pct = 85; end
			default: begin in_idle_pct = 18; out_stall_pct = 18; end
		endcase
		nv = (n > 64) ? 64 : n;
		start = words_sent;
		while (words_sent - start < budget) begin
			// large graphs are cleared each time to keep the solve short
			if (nv > 16 || $urandom_range(0, 5) == 0)
				send_word(mfpr_pkg::CMD_CLEAR, 6'($urandom), 6'($urandom), $urandom);
			k = (nv > 16) ? $urandom_range(1, 15) : $urandom_range(1, 12);
			repeat (k) begin
				a = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, nv-1));
				b = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, nv-1));
				if ($urandom_range(0, 19) == 0)
					send_word(mfpr_pkg::CMD_RSVD, 6'($urandom), 6'($urandom), $urandom);
				send_word(mfpr_pkg::CMD_ADD, a, b, pick_capacity());
			end
			send_word(mfpr_pkg::CMD_COMPUTE, 6'($urandom), 6'($urandom), $urandom);
		end
	endtask

	initial begin
		tracker = new();
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = mfpr_pkg::CMD_ADD;
		from_vertex = '0;
		to_vertex = '0;
		capacity = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = mfpr_pkg::CFG_SOURCE;
		cfg_data = '0;
		in_idle_pct = 0;
		out_stall_pct = 0;
		words_sent = 0;
		settings_used = 1;
		quiet_cycles = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: saturation, zero add, self loop, antiparallel, reserved cmd
		send_word(mfpr_pkg::CMD_COMPUTE, 0, 0, 0);
		send_word(mfpr_pkg::CMD_ADD, 0, 1, 32'hFFFF_FFFF);
		send_word(mfpr_pkg::CMD_ADD, 0, 1, 32'hFFFF_FFFF);
		send_word(mfpr_pkg::CMD_ADD, 0, 2, 5);
		send_word(mfpr_pkg::CMD_ADD, 2, 1, 3);
		send_word(mfpr_pkg::CMD_ADD, 2, 0, 4);
		send_word(mfpr_pkg::CMD_ADD, 1, 2, 0);
		send_word(mfpr_pkg::CMD_ADD, 3, 3, 7);
		send_word(mfpr_pkg::CMD_ADD, 2, 63, 10);
		send_word(mfpr_pkg::CMD_ADD, 63, 1, 6);
		send_word(mfpr_pkg::CMD_ADD, 0, 63, 32'h8000_0000);
		send_word(mfpr_pkg::CMD_ADD, 63, 0, 9);
		send_word(mfpr_pkg::CMD_RSVD, 6'h3F, 6'h3F, 32'hFFFF_FFFF);
		send_word(mfpr_pkg::CMD_COMPUTE, 0, 0, 0);
		send_word(mfpr_pkg::CMD_ADD, 1, 0, 12);
		send_word(mfpr_pkg::CMD_ADD, 2, 2, 32'hFFFF_FFFF);
		send_word(mfpr_pkg::CMD_COMPUTE, 6'h3F, 6'h3F, 32'hFFFF_FFFF);
		send_word(mfpr_pkg::CMD_CLEAR, 0, 0, 0);
		send_word(mfpr_pkg::CMD_COMPUTE, 0, 0, 0);
		send_word(mfpr_pkg::CMD_ADD, 0, 1, 0);
		send_word(mfpr_pkg::CMD_COMPUTE, 0, 0, 0);

		// source, sink, count, idle mode, words
		run_phase(5, 2, 8, 0, 150);
		run_phase(3, 3, 6, 1, 150);
		run_phase(0, 63, 2, 2, 150);
		run_phase(10, 1, 4, 3, 100);
		run_phase(2, 7, 5, 0, 150);
		run_phase(0, 1, 127, 3, 120);
		run_phase(63, 0, 64, 2, 120);
		run_phase(1, 0, 2, 1, 150);
		run_phase(4, 9, 12, 3, 150);

		@(negedge clk);
		in_valid <= 1'b0;
		while (tracker.pending_flows.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		$display("%0d words sent, %0d flow results checked over %0d register settings",
			words_sent, tracker.checked, settings_used);
		if (tracker.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule

`default_nettype wire

FILE: filelist.f
rtl/core/mfpr_pkg.sv
rtl/core/mfpr_ram.sv
rtl/core/max_flow_push_relabel_core.sv
bench/tb_max_flow_push_relabel_core.sv
